// File: hw/rtl/lra_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the LRA drive rating calculator.
// No dependencies; imported by every module of the block.
package lra_pkg;

	// APB register map
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	localparam logic [1:0] REG_IS_LRA       = 2'd0;
	localparam logic [1:0] REG_DEF_RATED    = 2'd1;
	localparam logic [1:0] REG_DEF_OVERDRV  = 2'd2;
	localparam logic [1:0] REG_DEF_SEED     = 2'd3;

	// operation codes
	localparam logic [1:0] FN_SET_RATINGS = 2'd0;
	localparam logic [1:0] FN_RESEED      = 2'd1;
	localparam logic [1:0] FN_RELOAD      = 2'd2;

	// field widths
	localparam int unsigned MV_W    = 13;
	localparam int unsigned HZ_W    = 9;
	localparam int unsigned CODE_W  = 8;
	localparam int unsigned DRV_W   = 5;
	localparam int unsigned ROOT_W  = 20;
	localparam int unsigned ROOTS_W = 10;
	localparam int unsigned REM_W   = 30;
	localparam int unsigned DEN_W   = 22;

	// register reset values
	localparam logic          RST_IS_LRA     = 1'b1;
	localparam logic [MV_W-1:0] RST_RATED_MV = 13'd2000;
	localparam logic [MV_W-1:0] RST_OD_MV    = 13'd2500;
	localparam logic [HZ_W-1:0] RST_SEED_HZ  = 9'd235;
	localparam logic [DRV_W-1:0] RST_DRIVE   = 5'd16;
	// codes the formulas give for the reset ratings at 235 Hz, LRA
	localparam logic [CODE_W-1:0] RST_RATED_CODE = 8'd120;
	localparam logic [CODE_W-1:0] RST_OD_CODE    = 8'd146;

	// arithmetic constants
	localparam logic [REM_W-1:0]  DRV_NUM      = 30'd5000;   // 500000 / 100
	localparam logic [CODE_W-1:0] DRV_Q_SAT    = 8'd36;
	localparam logic [CODE_W-1:0] DRV_Q_OFS    = 8'd5;
	localparam logic [DRV_W-1:0]  DRV_MAX      = 5'd31;
	localparam logic [9:0]        DEAD_MAX     = 10'd999;
	localparam logic [9:0]        K_THOUSAND   = 10'd1000;
	localparam logic [REM_W-1:0]  K_MV_SCALE   = 30'd100000;
	localparam logic [DEN_W-1:0]  K_RATED_DEN  = 22'd2058;
	localparam logic [DEN_W-1:0]  K_OD_DEN     = 22'd2122;
	localparam logic [ROOT_W-1:0] SQ_BIT_INIT  = 20'h40000;
	localparam logic [ROOT_W-1:0] S_ERM        = 20'd1000;
	localparam logic [CODE_W-1:0] CODE_SAT     = 8'hFF;
	localparam logic [7:0]        RESEED_MIN   = 8'd50;
	localparam logic [7:0]        K_RATED_STEP = 8'd20;
	localparam logic [7:0]        K_OD_STEP    = 8'd25;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DRV_LOAD,
		ST_DRV_SAT,
		ST_DRV_DIV,
		ST_DRV_FIN,
		ST_SQ_LOAD,
		ST_SQ_STEP,
		ST_V_LOAD,
		ST_V_SAT,
		ST_V_DIV,
		ST_V_FIN,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic              is_lra;
		logic [MV_W-1:0]   def_rated_mv;
		logic [MV_W-1:0]   def_od_mv;
		logic [HZ_W-1:0]   def_seed_hz;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_status_t;

	typedef struct packed {
		logic [CODE_W-1:0] rated_code;
		logic [CODE_W-1:0] od_code;
		logic [DRV_W-1:0]  drive_code;
		logic [HZ_W-1:0]   seed_hz;
	} eng_result_t;

endpackage

// File: hw/rtl/lra_drive_rating_calculator_core.sv
`timescale 1ns / 1ps
// Top level of the LRA drive rating calculator.
// Depends on lra_pkg, lra_cfg_regs and lra_calc_engine.
//
// Usage:
//  Request channel (req_valid/req_stall, func, param) takes one command; the
//  response channel (rsp_valid/rsp_stall) returns the rated, overdrive and
//  drive-time codes plus the seed in use, one response per command.
//  A command runs on one compare/subtract unit under a sequencer: a drive-time
//  division (reseed, reload), a 10-step square root (LRA only) and two code
//  divisions, each division cut short when its quotient saturates, then a done
//  state that hands the result over. A no-op command goes straight to that
//  state. req_stall stays high from acceptance until the sequencer is idle
//  again, so no new command is taken until the current one is done.
//  The response sits in an output register; the next command may be accepted
//  while it waits. If rsp_stall holds a response, a finished command waits in
//  its last step until the register frees up.
//  Reset (arst_n low) loads the default registers and state: 2000/2500 mV,
//  235 Hz, drive code 16, held codes 120/146. The user must write registers
//  over APB only while idle, which the block does not enforce; they take effect at the next command.
module lra_drive_rating_calculator_core
	import lra_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         func,
	input  logic [7:0]         param,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [CODE_W-1:0]  rated_code,
	output logic [CODE_W-1:0]  overdrive_code,
	output logic [DRV_W-1:0]   drive_code,
	output logic [HZ_W-1:0]    seed_freq,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t        cfg;
	eng_status_t eng_st;
	eng_result_t eng_res;
	eng_result_t rsp_q;
	logic        rsp_valid_q;
	logic        out_free;
	logic        start;

	assign pready    = 1'b1;
	assign req_stall = eng_st.busy;
	assign start     = req_valid & ~eng_st.busy;
	assign out_free  = ~rsp_valid_q | ~rsp_stall;

	lra_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	lra_calc_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.start    (start),
		.func     (func),
		.param    (param),
		.out_free (out_free),
		.status   (eng_st),
		.result   (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (eng_st.done && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_st.done && out_free) rsp_q <= eng_res;
	end

	assign rsp_valid      = rsp_valid_q;
	assign rated_code     = rsp_q.rated_code;
	assign overdrive_code = rsp_q.od_code;
	assign drive_code     = rsp_q.drive_code;
	assign seed_freq      = rsp_q.seed_hz;

endmodule

// File: hw/rtl/lra_csub_unit.sv
`timescale 1ns / 1ps
// Shared compare/subtract unit: the one compare/subtract element used by the
// square root and the restoring drive-time and code divisions. Depends on lra_pkg.
module lra_csub_unit
	import lra_pkg::*;
(
	input  logic [REM_W-1:0] a,
	input  logic [REM_W-1:0] b,
	output logic             ge,
	output logic [REM_W-1:0] diff
);

	logic [REM_W:0] sub;

	assign sub  = {1'b0, a} - {1'b0, b};
	assign ge   = ~sub[REM_W];
	assign diff = sub[REM_W-1:0];

endmodule

// File: hw/rtl/lra_cfg_regs.sv
`timescale 1ns / 1ps
// APB configuration registers: actuator type and default ratings/seed.
// Depends on lra_pkg.
module lra_cfg_regs
	import lra_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.is_lra       <= RST_IS_LRA;
			cfg_q.def_rated_mv <= RST_RATED_MV;
			cfg_q.def_od_mv    <= RST_OD_MV;
			cfg_q.def_seed_hz  <= RST_SEED_HZ;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IS_LRA:      cfg_q.is_lra       <= pwdata[0];
				REG_DEF_RATED:   cfg_q.def_rated_mv <= pwdata[MV_W-1:0];
				REG_DEF_OVERDRV: cfg_q.def_od_mv    <= pwdata[MV_W-1:0];
				REG_DEF_SEED:    cfg_q.def_seed_hz  <= pwdata[HZ_W-1:0];
				default:         cfg_q.is_lra       <= cfg_q.is_lra;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_IS_LRA:      prdata = {{(PDATA_W-1){1'b0}}, cfg_q.is_lra};
			REG_DEF_RATED:   prdata = {{(PDATA_W-MV_W){1'b0}}, cfg_q.def_rated_mv};
			REG_DEF_OVERDRV: prdata = {{(PDATA_W-MV_W){1'b0}}, cfg_q.def_od_mv};
			REG_DEF_SEED:    prdata = {{(PDATA_W-HZ_W){1'b0}}, cfg_q.def_seed_hz};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/lra_calc_engine.sv
`timescale 1ns / 1ps
// Sequencer and datapath: holds the actuator state and runs the drive-time
// division, the dead-time square root and the two code divisions through one
// shared compare/subtract unit. Depends on lra_pkg and lra_csub_unit.
module lra_calc_engine
	import lra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        start,
	input  logic [1:0]  func,
	input  logic [7:0]  param,
	input  logic        out_free,
	output eng_status_t status,
	output eng_result_t result
);

	st_t state_q, state_d;

	// architectural state
	logic [MV_W-1:0]   rated_mv_q, od_mv_q;
	logic [HZ_W-1:0]   seed_q;
	logic [DRV_W-1:0]  drive_q;
	logic [CODE_W-1:0] rated_code_q, od_code_q;

	// work registers
	logic [REM_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [ROOT_W-1:0] root_q, bit_q;
	logic [CODE_W-1:0] quo_q;
	logic [2:0]        cnt_q;
	logic              od_phase_q;

	logic              reseed_ok;
	logic [REM_W-1:0]  op_b, csub_diff;
	logic              csub_ge;
	logic [10:0]       tri_hz;
	logic [9:0]        dead_raw, dead, margin;
	logic [ROOT_W-1:0] v_init;
	logic [ROOTS_W-1:0] s_val;
	logic [MV_W-1:0]   mv_sel;
	logic [REM_W-1:0]  num_val;
	logic [DEN_W-1:0]  den_val;
	logic [ROOT_W-1:0] sq_sum;

	assign reseed_ok = (param >= RESEED_MIN) && cfg.is_lra;

	// dead-time term: min(999, 3*hz/2), radicand (1000 - dead) * 1000
	assign tri_hz   = {2'b00, seed_q} * 11'd3;
	assign dead_raw = tri_hz[10:1];
	assign dead     = (dead_raw > DEAD_MAX) ? DEAD_MAX : dead_raw;
	assign margin   = K_THOUSAND - dead;
	assign v_init   = {{(ROOT_W-10){1'b0}}, margin} * {{(ROOT_W-10){1'b0}}, K_THOUSAND};

	assign s_val   = root_q[ROOTS_W-1:0];
	assign mv_sel  = od_phase_q ? od_mv_q : rated_mv_q;
	assign num_val = {{(REM_W-MV_W){1'b0}}, mv_sel} * K_MV_SCALE;
	assign den_val = {{(DEN_W-ROOTS_W){1'b0}}, s_val} * (od_phase_q ? K_OD_DEN : K_RATED_DEN);
	assign sq_sum  = root_q + bit_q;

	// operand selection for the shared unit
	always_comb begin
		unique case (state_q)
			ST_DRV_SAT, ST_V_SAT: op_b = {den_q, 8'h00};
			ST_DRV_DIV, ST_V_DIV: op_b = {{(REM_W-DEN_W){1'b0}}, den_q} << cnt_q;
			ST_SQ_STEP:           op_b = {{(REM_W-ROOT_W){1'b0}}, sq_sum};
			default:              op_b = '0;
		endcase
	end

	lra_csub_unit u_csub (
		.a    (rem_q),
		.b    (op_b),
		.ge   (csub_ge),
		.diff (csub_diff)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					priority if (func == FN_SET_RATINGS) state_d = ST_SQ_LOAD;
					else if (func == FN_RESEED && reseed_ok) state_d = ST_DRV_LOAD;
					else if (func == FN_RELOAD) state_d = ST_DRV_LOAD;
					else state_d = ST_DONE;
				end
			end
			ST_DRV_LOAD: state_d = ST_DRV_SAT;
			ST_DRV_SAT:  state_d = csub_ge ? ST_DRV_FIN : ST_DRV_DIV;
			ST_DRV_DIV:  state_d = (cnt_q == 3'd0) ? ST_DRV_FIN : ST_DRV_DIV;
			ST_DRV_FIN:  state_d = ST_SQ_LOAD;
			ST_SQ_LOAD:  state_d = cfg.is_lra ? ST_SQ_STEP : ST_V_LOAD;
			ST_SQ_STEP:  state_d = bit_q[0] ? ST_V_LOAD : ST_SQ_STEP;
			ST_V_LOAD:   state_d = ST_V_SAT;
			ST_V_SAT:    state_d = csub_ge ? ST_V_FIN : ST_V_DIV;
			ST_V_DIV:    state_d = (cnt_q == 3'd0) ? ST_V_FIN : ST_V_DIV;
			ST_V_FIN:    state_d = od_phase_q ? ST_DONE : ST_V_LOAD;
			ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// status outputs
	always_comb begin
		status.busy = (state_q != ST_IDLE);
		status.done = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rated_mv_q   <= RST_RATED_MV;
			od_mv_q      <= RST_OD_MV;
			seed_q       <= RST_SEED_HZ;
			drive_q      <= RST_DRIVE;
			rated_code_q <= RST_RATED_CODE;
			od_code_q    <= RST_OD_CODE;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				unique case (func)
					FN_SET_RATINGS: begin
						if (param == 8'd0) begin
							rated_mv_q <= cfg.def_rated_mv;
							od_mv_q    <= cfg.def_od_mv;
						end else begin
							// overdrive = rated * 5/4 = param * 25, exact
							rated_mv_q <= {5'b0, param} * {5'b0, K_RATED_STEP};
							od_mv_q    <= {5'b0, param} * {5'b0, K_OD_STEP};
						end
					end
					FN_RESEED: begin
						if (reseed_ok) seed_q <= {param, 1'b0};
					end
					FN_RELOAD: begin
						rated_mv_q <= cfg.def_rated_mv;
						od_mv_q    <= cfg.def_od_mv;
						seed_q     <= cfg.def_seed_hz;
					end
					default: begin
						seed_q <= seed_q;
					end
				endcase
			end
			if (state_q == ST_DRV_FIN) begin
				// code = floor(5000/hz) - 5, saturated
				drive_q <= (quo_q >= DRV_Q_SAT) ? DRV_MAX : DRV_W'(quo_q - DRV_Q_OFS);
			end
			if (state_q == ST_V_FIN) begin
				if (od_phase_q) od_code_q <= quo_q;
				else rated_code_q <= quo_q;
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_DRV_LOAD: begin
				rem_q <= DRV_NUM;
				den_q <= {{(DEN_W-HZ_W){1'b0}}, seed_q};
				quo_q <= '0;
				cnt_q <= 3'd7;
			end
			ST_DRV_SAT, ST_V_SAT: begin
				if (csub_ge) quo_q <= CODE_SAT;
			end
			ST_DRV_DIV, ST_V_DIV: begin
				if (csub_ge) rem_q <= csub_diff;
				quo_q <= {quo_q[CODE_W-2:0], csub_ge};
				cnt_q <= cnt_q - 3'd1;
			end
			ST_SQ_LOAD: begin
				od_phase_q <= 1'b0;
				if (cfg.is_lra) begin
					rem_q  <= {{(REM_W-ROOT_W){1'b0}}, v_init};
					root_q <= '0;
					bit_q  <= SQ_BIT_INIT;
				end else begin
					root_q <= S_ERM;
				end
			end
			ST_SQ_STEP: begin
				if (csub_ge) begin
					rem_q  <= csub_diff;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_V_LOAD: begin
				rem_q <= num_val;
				den_q <= den_val;
				quo_q <= '0;
				cnt_q <= 3'd7;
			end
			ST_V_FIN: begin
				od_phase_q <= 1'b1;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign result.rated_code = rated_code_q;
	assign result.od_code    = od_code_q;
	assign result.drive_code = drive_q;
	assign result.seed_hz    = seed_q;

endmodule

// File: hw/rtl/lra_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the LRA drive rating calculator, bound to the top.
// Depends on lra_pkg.
module lra_chk
	import lra_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic [CODE_W-1:0]  rated_code,
	input logic [CODE_W-1:0]  overdrive_code,
	input logic [DRV_W-1:0]   drive_code,
	input logic [HZ_W-1:0]    seed_freq
);

	// a held response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rated_code)
			&& $stable(overdrive_code) && $stable(drive_code) && $stable(seed_freq))
		else $error("stalled response changed");

	// an accepted command makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("block not busy after accepting a command");

	// a new response only shows up after the block was busy
	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without a command in flight");

	// seeds of 138 Hz and below always saturate the drive-time code
	a_drive_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (seed_freq <= 9'd138) |-> (drive_code == DRV_MAX))
		else $error("drive code not saturated for low seed");

endmodule

bind lra_drive_rating_calculator_core lra_chk u_lra_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req_valid),
	.req_stall      (req_stall),
	.rsp_valid      (rsp_valid),
	.rsp_stall      (rsp_stall),
	.rated_code     (rated_code),
	.overdrive_code (overdrive_code),
	.drive_code     (drive_code),
	.seed_freq      (seed_freq)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for lra_drive_rating_calculator_core: directed and random commands with
// APB register changes; every response is checked against a predictor of the rating math.
// Depends on lra_pkg and the core RTL only.
module tb_top;
	import lra_pkg::*;

	localparam logic [1:0]  FN_UNUSED     = 2'd3;
	localparam int unsigned RATED_DIV     = 2058;
	localparam int unsigned OD_DIV        = 2122;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned RAND_ITEMS    = 610;
	localparam int unsigned CFG_EVERY     = 122;

	typedef struct packed {
		logic [CODE_W-1:0] rated;
		logic [CODE_W-1:0] od;
		logic [DRV_W-1:0]  drive;
		logic [HZ_W-1:0]   seed;
	} codes_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         func      = '0;
	logic [7:0]         param     = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [CODE_W-1:0]  rated_code;
	logic [CODE_W-1:0]  overdrive_code;
	logic [DRV_W-1:0]   drive_code;
	logic [HZ_W-1:0]    seed_freq;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// register copies and block state as the predictor sees them
	logic              cfg_is_lra;
	logic [MV_W-1:0]   cfg_rated_mv;
	logic [MV_W-1:0]   cfg_od_mv;
	logic [HZ_W-1:0]   cfg_seed_hz;
	logic [MV_W-1:0]   cur_rated_mv;
	logic [MV_W-1:0]   cur_od_mv;
	logic [9:0]        cur_seed_hz;
	logic [DRV_W-1:0]  cur_drive;
	logic [CODE_W-1:0] cur_rated_code;
	logic [CODE_W-1:0] cur_od_code;

	codes_t      codes_due[$];
	codes_t      head;
	int unsigned err_count   = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;

	lra_drive_rating_calculator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.func          (func),
		.param         (param),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rated_code    (rated_code),
		.overdrive_code(overdrive_code),
		.drive_code    (drive_code),
		.seed_freq     (seed_freq),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// ---------------- predictor ----------------

	function automatic int unsigned root_of(input int unsigned v);
		int unsigned acc;
		int unsigned trial;
		int          i;
		acc = 0;
		for (i = 9; i >= 0; i--) begin
			trial = acc | (1 << i);
			if (trial * trial <= v)
				acc = trial;
		end
		return acc;
	endfunction

	function automatic logic [DRV_W-1:0] drive_of(input int unsigned hz);
		int unsigned half;
		if (hz == 0)
			return 5'd31;
		half = 500000 / hz;
		if (half < 500)
			return 5'd0;
		half = (half - 500) / 100;
		return (half > 31) ? 5'd31 : 5'(half);
	endfunction

	function automatic logic [CODE_W-1:0] volt_code(input int unsigned mv,
			input int unsigned den, input int unsigned s);
		longint unsigned q;
		q = (longint'(mv) * 100000) / (longint'(den) * s);
		return (q > 255) ? 8'hFF : 8'(q);
	endfunction

	task automatic refresh_codes(input logic lra);
		int unsigned dead;
		int unsigned s;
		s = 1000;
		if (lra) begin
			dead = (1500 * cur_seed_hz) / 1000;
			if (dead > 999)
				dead = 999;
			s = root_of((1000 - dead) * 1000);
		end
		cur_rated_code = volt_code(cur_rated_mv, RATED_DIV, s);
		cur_od_code    = volt_code(cur_od_mv, OD_DIV, s);
	endtask

	task automatic reset_model();
		cfg_is_lra   = RST_IS_LRA;
		cfg_rated_mv = 13'd2000;
		cfg_od_mv    = 13'd2500;
		cfg_seed_hz  = 9'd235;
		cur_rated_mv = 13'd2000;
		cur_od_mv    = 13'd2500;
		cur_seed_hz  = 10'd235;
		cur_drive    = 5'd16;
		refresh_codes(1'b1);
	endtask

	task automatic apply_command(input logic [1:0] f, input logic [7:0] p);
		codes_t c;
		case (f)
			FN_SET_RATINGS: begin
				if (p == 0) begin
					cur_rated_mv = cfg_rated_mv;
					cur_od_mv    = cfg_od_mv;
				end else begin
					cur_rated_mv = 13'(int'(p) * 20);
					cur_od_mv    = 13'((int'(cur_rated_mv) * 5) / 4);
				end
				refresh_codes(cfg_is_lra);
			end
			FN_RESEED: begin
				if (p >= 50 && cfg_is_lra) begin
					cur_seed_hz = 10'(int'(p) * 2);
					cur_drive   = drive_of(cur_seed_hz);
					refresh_codes(cfg_is_lra);
				end
			end
			FN_RELOAD: begin
				cur_rated_mv = cfg_rated_mv;
				cur_od_mv    = cfg_od_mv;
				cur_seed_hz  = {1'b0, cfg_seed_hz};
				cur_drive    = drive_of(cur_seed_hz);
				refresh_codes(cfg_is_lra);
			end
			default: ;  // unused op leaves state alone
		endcase
		c.rated = cur_rated_code;
		c.od    = cur_od_code;
		c.drive = cur_drive;
		c.seed  = cur_seed_hz[HZ_W-1:0];
		codes_due.push_back(c);
	endtask

	// ---------------- checking ----------------

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= 100)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// outputs are stable at the falling edge; a transaction completes at the next rise
	always @(negedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (codes_due.size() == 0) begin
				report_mismatch("response with no command outstanding");
			end else begin
				head = codes_due.pop_front();
				check_field("rated_code", rated_code, head.rated);
				check_field("overdrive_code", overdrive_code, head.od);
				check_field("drive_code", drive_code, head.drive);
				check_field("seed_freq", seed_freq, head.seed);
			end
		end
	end

	// ---------------- drivers ----------------

	// called and returns just after a rising edge
	task automatic send_cmd(input logic [1:0] f, input logic [7:0] p);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		func      <= f;
		param     <= p;
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		apply_command(f, p);
		@(posedge clk);
	endtask

	task automatic settle(input int unsigned cycles);
		req_valid <= 1'b0;
		wait (codes_due.size() == 0);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_IS_LRA:      cfg_is_lra   = value[0];
			REG_DEF_RATED:   cfg_rated_mv = value[MV_W-1:0];
			REG_DEF_OVERDRV: cfg_od_mv    = value[MV_W-1:0];
			REG_DEF_SEED:    cfg_seed_hz  = value[HZ_W-1:0];
			default: ;
		endcase
	endtask

	// ---------------- tests ----------------

	task automatic test_reset_state();
		send_cmd(FN_UNUSED, 8'd0);
	endtask

	task automatic test_set_ratings();
		send_cmd(FN_SET_RATINGS, 8'd0);
		send_cmd(FN_SET_RATINGS, 8'd1);
		send_cmd(FN_SET_RATINGS, 8'd255);
		send_cmd(FN_SET_RATINGS, 8'd200);
		settle(8);
		write_reg(REG_IS_LRA, 0);
		send_cmd(FN_SET_RATINGS, 8'd255);
		send_cmd(FN_SET_RATINGS, 8'd1);
		settle(8);
		write_reg(REG_IS_LRA, 1);
	endtask

	task automatic test_reseed();
		send_cmd(FN_RESEED, 8'd49);   // just below the threshold: no change
		send_cmd(FN_RESEED, 8'd50);
		send_cmd(FN_RESEED, 8'd255);
		send_cmd(FN_RESEED, 8'd125);
		settle(8);
		write_reg(REG_IS_LRA, 0);
		send_cmd(FN_RESEED, 8'd200);  // ERM ignores reseed
		settle(8);
		write_reg(REG_IS_LRA, 1);
	endtask

	task automatic test_reload_defaults();
		settle(8);
		write_reg(REG_DEF_RATED, 6375);
		write_reg(REG_DEF_OVERDRV, 6375);
		write_reg(REG_DEF_SEED, 510);
		send_cmd(FN_RELOAD, 8'd255);
		settle(8);
		write_reg(REG_DEF_RATED, 0);
		write_reg(REG_DEF_OVERDRV, 0);
		write_reg(REG_DEF_SEED, 100);
		send_cmd(FN_RELOAD, 8'd0);
		settle(8);
		write_reg(REG_DEF_RATED, 5000);
		write_reg(REG_DEF_SEED, 0);   // zero seed: saturated drive, unscaled root
		send_cmd(FN_RELOAD, 8'd85);
		settle(8);
		write_reg(REG_IS_LRA, 0);
		write_reg(REG_DEF_SEED, 300);
		send_cmd(FN_RELOAD, 8'd170);
		settle(8);
		write_reg(REG_IS_LRA, 1);
		write_reg(REG_DEF_RATED, 2000);
		write_reg(REG_DEF_OVERDRV, 2500);
		write_reg(REG_DEF_SEED, 235);
		send_cmd(FN_RELOAD, 8'd0);
	endtask

	task automatic test_unused_op();
		send_cmd(FN_UNUSED, 8'd255);
		send_cmd(FN_UNUSED, 8'd170);
	endtask

	task automatic randomize_regs();
		write_reg(REG_IS_LRA, ($urandom_range(3) != 0) ? 1 : 0);
		write_reg(REG_DEF_RATED, $urandom_range(6375));
		write_reg(REG_DEF_OVERDRV, $urandom_range(6375));
		write_reg(REG_DEF_SEED, ($urandom_range(19) == 0) ? 0 : $urandom_range(510, 100));
	endtask

	task automatic test_random(input int unsigned tx_pct, input int unsigned rx_pct);
		int unsigned n;
		int unsigned pick;
		logic [1:0]  f;
		logic [7:0]  p;
		settle(8);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n % CFG_EVERY == 0) begin
				settle(8);
				randomize_regs();
			end
			pick = $urandom_range(99);
			if (pick < 35)
				f = FN_SET_RATINGS;
			else if (pick < 75)
				f = FN_RESEED;
			else if (pick < 94)
				f = FN_RELOAD;
			else
				f = FN_UNUSED;
			p = 8'($urandom_range(255));
			if (f == FN_SET_RATINGS && $urandom_range(9) == 0)
				p = 8'd0;
			if (f == FN_RESEED && $urandom_range(3) != 0)
				p = 8'($urandom_range(255, 50));
			send_cmd(f, p);
		end
	endtask

	initial begin
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_set_ratings();
		test_reseed();
		test_reload_defaults();
		test_unused_op();
		test_random(33, 79);
		test_random(79, 33);
		test_random(0, 0);
		settle(SETTLE_CYCLES);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/lra_pkg.sv
hw/rtl/lra_csub_unit.sv
hw/rtl/lra_cfg_regs.sv
hw/rtl/lra_calc_engine.sv
hw/rtl/lra_drive_rating_calculator_core.sv
hw/rtl/lra_chk.sv
sim/tb_top.sv
